// File: src/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, sideband types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int COMP_BITS     = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STEPS  = 16;

    localparam int PROD_W        = 2 * COMP_BITS;       // one component product
    localparam int SUM_W         = PROD_W + 3;          // scaled sums, signed
    localparam int MAG_W         = PROD_W + 1;          // magnitude of a scaled sum
    localparam int NORM_W        = 31;                  // n2 after range reduction
    localparam int SQ_W          = 2 * NORM_W;          // n*n, a*a
    localparam int ISQRT_W       = SQ_W + 1;
    localparam int ISQRT_STAGES  = SQ_W / 2 + 1;
    localparam int CW            = 34;                  // CORDIC x, y, z width
    localparam int NORM_TOP      = 29;                  // normalized top bit
    localparam int NORM_DROP     = MAG_W - 1 - NORM_TOP;
    localparam int ROUND_SHIFT   = 32 - ANGLE_BITS;

    localparam logic signed [CW-1:0] Z_PI       = CW'(64'sd2147483648);
    localparam logic signed [CW-1:0] Z_HALF_PI  = CW'(64'sd1073741824);

    typedef enum logic [2:0] {
        SPC_NONE,
        SPC_ZERO,
        SPC_POS_HALF,
        SPC_NEG_HALF,
        SPC_PI
    } special_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] nr;
        logic signed [SUM_W-1:0] dr;
        logic signed [SUM_W-1:0] ny;
        logic signed [SUM_W-1:0] dy;
        logic                    neg;
        logic [NORM_W-1:0]       a;
        logic                    zero;
    } side_t;

    // atan(2^-i), pi = 2^31
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/qte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_front
// Products, scaled sums, pitch clamp and the radicand n^2 - a^2 (5 stages).
// ----------------------------------------------------------------------------
module qte_front
(
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [qte_pkg::COMP_BITS-1:0] q_w,
    input  logic signed [qte_pkg::COMP_BITS-1:0] q_x,
    input  logic signed [qte_pkg::COMP_BITS-1:0] q_y,
    input  logic signed [qte_pkg::COMP_BITS-1:0] q_z,
    output logic                                out_valid,
    output logic [qte_pkg::SQ_W-1:0]            out_d,
    output qte_pkg::side_t                      out_side
);
    import qte_pkg::*;

    logic [4:0] v_reg;

    // stage 1: products
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, zx_reg;
    logic                     z1_reg;

    // stage 2: sums
    logic signed [SUM_W-1:0]  n2_reg, nr2_reg, dr2_reg, ny2_reg, dy2_reg, sp_reg;
    logic                     z2_reg;
    logic signed [SUM_W-1:0]  n2_next, nr2_next, dr2_next, ny2_next, dy2_next, sp_next;

    // stage 3: clamp and range reduction
    side_t                    s3_reg, s3_next;
    logic [NORM_W-1:0]        n3_reg, n3_next;

    // stage 4: squares
    side_t                    s4_reg;
    logic [SQ_W-1:0]          nn_reg, aa_reg;

    // stage 5: radicand
    side_t                    s5_reg;
    logic [SQ_W-1:0]          d_reg;

    always_comb begin
        n2_next  = SUM_W'(ww_reg) + SUM_W'(xx_reg) + SUM_W'(yy_reg) + SUM_W'(zz_reg);
        nr2_next = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        dr2_next = n2_next - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        ny2_next = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        dy2_next = n2_next - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
        sp_next  = (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
    end

    always_comb begin
        logic signed [SUM_W-1:0] sp_c;
        logic signed [SUM_W-1:0] sp_m;
        logic [MAG_W-1:0]        a_m;
        logic [MAG_W-1:0]        n_m;
        sp_c = sp_reg;
        if (sp_c > n2_reg) begin
            sp_c = n2_reg;
        end
        if (sp_c < -n2_reg) begin
            sp_c = -n2_reg;
        end
        sp_m = sp_c[SUM_W-1] ? -sp_c : sp_c;
        a_m  = sp_m[MAG_W-1:0];
        n_m  = n2_reg[MAG_W-1:0];
        if (n_m[MAG_W-1]) begin
            n_m = n_m >> 2;
            a_m = a_m >> 2;
        end else if (n_m[MAG_W-2]) begin
            n_m = n_m >> 1;
            a_m = a_m >> 1;
        end
        s3_next.nr   = nr2_reg;
        s3_next.dr   = dr2_reg;
        s3_next.ny   = ny2_reg;
        s3_next.dy   = dy2_reg;
        s3_next.neg  = sp_c[SUM_W-1];
        s3_next.a    = a_m[NORM_W-1:0];
        s3_next.zero = z2_reg;
        n3_next      = n_m[NORM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ww_reg  <= q_w * q_w;
            xx_reg  <= q_x * q_x;
            yy_reg  <= q_y * q_y;
            zz_reg  <= q_z * q_z;
            wx_reg  <= q_w * q_x;
            yz_reg  <= q_y * q_z;
            wz_reg  <= q_w * q_z;
            xy_reg  <= q_x * q_y;
            wy_reg  <= q_w * q_y;
            zx_reg  <= q_z * q_x;
            z1_reg  <= (q_w == '0) && (q_x == '0) && (q_y == '0) && (q_z == '0);

            n2_reg  <= n2_next;
            nr2_reg <= nr2_next;
            dr2_reg <= dr2_next;
            ny2_reg <= ny2_next;
            dy2_reg <= dy2_next;
            sp_reg  <= sp_next;
            z2_reg  <= z1_reg;

            s3_reg  <= s3_next;
            n3_reg  <= n3_next;

            s4_reg  <= s3_reg;
            nn_reg  <= SQ_W'(n3_reg) * SQ_W'(n3_reg);
            aa_reg  <= SQ_W'(s3_reg.a) * SQ_W'(s3_reg.a);

            s5_reg  <= s4_reg;
            d_reg   <= nn_reg - aa_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign out_d     = d_reg;
    assign out_side  = s5_reg;

endmodule

// File: src/qte_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_isqrt
// Floor integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module qte_isqrt
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [qte_pkg::SQ_W-1:0]     in_d,
    output logic                         out_valid,
    output logic [qte_pkg::NORM_W-1:0]   out_root
);
    import qte_pkg::*;

    logic [ISQRT_W-1:0] d_reg [0:ISQRT_STAGES];
    logic [ISQRT_W-1:0] r_reg [0:ISQRT_STAGES];
    logic [ISQRT_STAGES:0] v_reg;

    always_comb begin
        d_reg[0] = ISQRT_W'(in_d);
        r_reg[0] = '0;
        v_reg[0] = in_valid;
    end

    for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_step
        localparam logic [ISQRT_W-1:0] BIT_K = ISQRT_W'(1) << (SQ_W - 2 * k);
        logic [ISQRT_W-1:0] trial;
        assign trial = r_reg[k] + BIT_K;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (d_reg[k] >= trial) begin
                    d_reg[k+1] <= d_reg[k] - trial;
                    r_reg[k+1] <= (r_reg[k] >> 1) + BIT_K;
                end else begin
                    d_reg[k+1] <= d_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[ISQRT_STAGES];
    assign out_root  = r_reg[ISQRT_STAGES][NORM_W-1:0];

endmodule

// File: src/qte_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined atan2: special-case detect, two normalize stages,
// CORDIC_STEPS vectoring stages and a rounding stage.
// ----------------------------------------------------------------------------
module qte_cordic
(
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [qte_pkg::SUM_W-1:0]     in_y,
    input  logic signed [qte_pkg::SUM_W-1:0]     in_x,
    input  logic                                 in_tag,
    output logic                                 out_valid,
    output logic [qte_pkg::ANGLE_BITS-1:0]       out_angle,
    output logic                                 out_tag
);
    import qte_pkg::*;

    localparam int NS = CORDIC_STEPS;

    // stage 1
    logic             v1_reg, t1_reg, ny1_reg, nx1_reg;
    logic [MAG_W-1:0] my1_reg, mx1_reg;
    special_t         sp1_reg, sp1_next;
    logic signed [SUM_W-1:0] my_s, mx_s;

    // stage 2
    logic             v2_reg, t2_reg, ny2_reg, nx2_reg;
    logic [MAG_W-1:0] my2_reg, mx2_reg, m2_reg;
    special_t         sp2_reg;
    logic [MAG_W-1:0] my2_next, mx2_next, m2_next;

    // vectoring pipeline
    logic signed [CW-1:0] x_reg [0:NS];
    logic signed [CW-1:0] y_reg [0:NS];
    logic signed [CW-1:0] z_reg [0:NS];
    special_t             sp_reg [0:NS];
    logic [NS:0]          t_reg;
    logic [NS:0]          v_reg;
    logic signed [CW-1:0] x0_next, y0_next, z0_next;

    // output stage
    logic                  vo_reg, to_reg;
    logic [ANGLE_BITS-1:0] ang_reg;
    logic signed [CW-1:0]  zf;
    logic signed [CW-1:0]  zr;

    assign my_s = in_y[SUM_W-1] ? -in_y : in_y;
    assign mx_s = in_x[SUM_W-1] ? -in_x : in_x;

    always_comb begin
        if (in_x == '0 && in_y == '0) begin
            sp1_next = SPC_ZERO;
        end else if (in_x == '0) begin
            sp1_next = in_y[SUM_W-1] ? SPC_NEG_HALF : SPC_POS_HALF;
        end else if (in_y == '0) begin
            sp1_next = in_x[SUM_W-1] ? SPC_PI : SPC_ZERO;
        end else begin
            sp1_next = SPC_NONE;
        end
    end

    // coarse leading-zero shifts
    always_comb begin
        my2_next = my1_reg;
        mx2_next = mx1_reg;
        m2_next  = my1_reg | mx1_reg;
        if (m2_next[MAG_W-1 -: 32] == '0) begin
            m2_next = m2_next << 32; my2_next = my2_next << 32; mx2_next = mx2_next << 32;
        end
        if (m2_next[MAG_W-1 -: 16] == '0) begin
            m2_next = m2_next << 16; my2_next = my2_next << 16; mx2_next = mx2_next << 16;
        end
        if (m2_next[MAG_W-1 -: 8] == '0) begin
            m2_next = m2_next << 8; my2_next = my2_next << 8; mx2_next = mx2_next << 8;
        end
    end

    // fine shifts, scale to top bit NORM_TOP, fold left half-plane
    always_comb begin
        logic [MAG_W-1:0]     m, my, mx;
        logic signed [CW-1:0] ys, xs;
        m  = m2_reg;
        my = my2_reg;
        mx = mx2_reg;
        if (m[MAG_W-1 -: 4] == '0) begin
            m = m << 4; my = my << 4; mx = mx << 4;
        end
        if (m[MAG_W-1 -: 2] == '0) begin
            m = m << 2; my = my << 2; mx = mx << 2;
        end
        if (!m[MAG_W-1]) begin
            my = my << 1; mx = mx << 1;
        end
        ys = CW'(my >> NORM_DROP);
        xs = CW'(mx >> NORM_DROP);
        if (ny2_reg) begin
            ys = -ys;
        end
        if (nx2_reg && xs != '0) begin
            z0_next = ys[CW-1] ? -Z_PI : Z_PI;
            x0_next = xs;
            y0_next = -ys;
        end else begin
            z0_next = '0;
            x0_next = xs;
            y0_next = ys;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg    <= in_tag;
            ny1_reg   <= in_y[SUM_W-1];
            nx1_reg   <= in_x[SUM_W-1];
            my1_reg   <= my_s[MAG_W-1:0];
            mx1_reg   <= mx_s[MAG_W-1:0];
            sp1_reg   <= sp1_next;

            t2_reg    <= t1_reg;
            ny2_reg   <= ny1_reg;
            nx2_reg   <= nx1_reg;
            my2_reg   <= my2_next;
            mx2_reg   <= mx2_next;
            m2_reg    <= m2_next;
            sp2_reg   <= sp1_reg;

            x_reg[0]  <= x0_next;
            y_reg[0]  <= y0_next;
            z_reg[0]  <= z0_next;
            sp_reg[0] <= sp2_reg;
            t_reg[0]  <= t2_reg;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_rot
        localparam logic signed [CW-1:0] ATAN_K = CW'(atan_entry(5'(k)));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[k][CW-1]) begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + ATAN_K;
                end else begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - ATAN_K;
                end
                sp_reg[k+1] <= sp_reg[k];
                t_reg[k+1]  <= t_reg[k];
            end
        end
    end

    always_comb begin
        case (sp_reg[NS])
            SPC_NONE:     zf = z_reg[NS];
            SPC_ZERO:     zf = '0;
            SPC_POS_HALF: zf = Z_HALF_PI;
            SPC_NEG_HALF: zf = -Z_HALF_PI;
            SPC_PI:       zf = Z_PI;
            default:      zf = '0;
        endcase
        zr = zf + (CW'(1) <<< (ROUND_SHIFT - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= zr[31:ROUND_SHIFT];
            to_reg  <= t_reg[NS];
        end
    end

    assign out_valid = vo_reg;
    assign out_angle = ang_reg;
    assign out_tag   = to_reg;

endmodule

// File: src/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Quaternion (any common scale) to ZYX Euler binary angles, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one quaternion (w, x, y, z), signed components, per
//   transaction. Result channel m_*: roll, pitch, yaw (32768 = pi) and a
//   flag that marks an all-zero quaternion (angles then read zero).
//   Pipeline: 5 front stages, 32 square-root stages, 20 CORDIC stages from
//   input transaction to result valid. Throughput: one transaction per cycle
//   unless stalled; the 32-stage square root and the 16-step CORDIC units
//   are fully unrolled, one step per stage.
//   Roll and yaw operands ride a 32-deep delay line beside the square root
//   so all three CORDIC units start together.
//   Stall: the whole pipeline advances on one enable; when m_ready is low
//   with a result waiting, every stage holds and s_ready drops, so nothing
//   is lost or repeated.
//   Reset (aresetn low, synchronous) clears all valid bits; data registers
//   are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles
(
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [qte_pkg::COMP_BITS-1:0] s_q_w,
    input  logic signed [qte_pkg::COMP_BITS-1:0] s_q_x,
    input  logic signed [qte_pkg::COMP_BITS-1:0] s_q_y,
    input  logic signed [qte_pkg::COMP_BITS-1:0] s_q_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [qte_pkg::ANGLE_BITS-1:0] m_roll_angle,
    output logic signed [qte_pkg::ANGLE_BITS-1:0] m_pitch_angle,
    output logic signed [qte_pkg::ANGLE_BITS-1:0] m_yaw_angle,
    output logic                                 m_zero_input
);
    import qte_pkg::*;

    logic en;

    // front end
    logic            f_valid;
    logic [SQ_W-1:0] f_d;
    side_t           f_side;

    // square root and matched sideband delay
    logic              r_valid;
    logic [NORM_W-1:0] r_root;
    side_t             side_reg [0:ISQRT_STAGES-1];
    side_t             side_q;

    // pitch operands
    logic signed [SUM_W-1:0] p_y, p_x;

    logic                  roll_valid, pitch_valid, yaw_valid;
    logic                  roll_tag, pitch_tag, yaw_tag;
    logic [ANGLE_BITS-1:0] roll_ang, pitch_ang, yaw_ang;

    // global advance: move when the output slot is empty or being drained
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    qte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .q_w       (s_q_w),
        .q_x       (s_q_x),
        .q_y       (s_q_y),
        .q_z       (s_q_z),
        .out_valid (f_valid),
        .out_d     (f_d),
        .out_side  (f_side)
    );

    qte_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_d      (f_d),
        .out_valid (r_valid),
        .out_root  (r_root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= f_side;
            for (int i = 1; i < ISQRT_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign side_q = side_reg[ISQRT_STAGES-1];

    // asin(s/n2) as atan2(s, sqrt(n^2 - s^2))
    assign p_y = side_q.neg ? -SUM_W'(side_q.a) : SUM_W'(side_q.a);
    assign p_x = SUM_W'(r_root);

    qte_cordic u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_y      (side_q.nr),
        .in_x      (side_q.dr),
        .in_tag    (side_q.zero),
        .out_valid (roll_valid),
        .out_angle (roll_ang),
        .out_tag   (roll_tag)
    );

    qte_cordic u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_y      (p_y),
        .in_x      (p_x),
        .in_tag    (side_q.zero),
        .out_valid (pitch_valid),
        .out_angle (pitch_ang),
        .out_tag   (pitch_tag)
    );

    qte_cordic u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_y      (side_q.ny),
        .in_x      (side_q.dy),
        .in_tag    (side_q.zero),
        .out_valid (yaw_valid),
        .out_angle (yaw_ang),
        .out_tag   (yaw_tag)
    );

    // the three units run in lockstep; valids and tags agree
    assign m_valid       = roll_valid & pitch_valid & yaw_valid;
    assign m_roll_angle  = roll_ang;
    assign m_pitch_angle = pitch_ang;
    assign m_yaw_angle   = yaw_ang;
    assign m_zero_input  = roll_tag & pitch_tag & yaw_tag;

endmodule
